FILE: rtl/core/rwa_pkg.sv
// Shared types and constants for the rank assignment core.
`default_nettype none
package rwa_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 7;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_WRITE   = 6'b000100,
    S_OUT_RD  = 6'b001000,
    S_OUT_CAP = 6'b010000,
    S_OUT_VLD = 6'b100000
  } state_e;

  // compare stage qualifiers
  typedef struct packed {
    logic vld;
    logic ranked;
  } cmp_t;

  // selection status at end of a scan
  typedef struct packed {
    logic found;
    logic dup;
  } sel_t;

endpackage
`default_nettype wire

FILE: rtl/core/rank_assign_with_duplicate_abort_core.sv
// Rank assignment core: loads a set, ranks it by repeated minimum scans, streams ranks out.
// Ranking: after the last word of an n-element set, ranking takes up to n+1 rounds (one pass
//   over the value RAM per round), then each result goes through S_OUT_RD, S_OUT_CAP and S_OUT_VLD.
// Throughput: one set at a time; a new set is not accepted until its last result is taken.
//   Input words are taken one per cycle while loading.
// Reset: clears control state, counters and ranked flags; RAM contents are not cleared.
`default_nettype none
module rank_assign_with_duplicate_abort_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic        s_axis_tlast_i,   // is_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,   // [6:0] rank, [7] zero
  output logic      [1:0]  m_axis_tuser_o,   // [0] duplicate_abort, [1] overflow
  output logic             m_axis_tlast_o    // last_result
);

  localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned RW    = rwa_pkg::RANK_W;

  rwa_pkg::state_e      state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 abort_q, abort_d;
  logic [RW-1:0]        round_q, round_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [MAX_ITEMS-1:0] ranked_q, ranked_d;
  logic [IDX_W-1:0]     out_cnt_q, out_cnt_d;
  logic                 out_vld_q, out_vld_d;
  logic [RW-1:0]        out_rank_q, out_rank_d;
  logic                 out_last_q, out_last_d;

  logic                 s_acc;
  logic                 val_we, val_re, rank_we, rank_re;
  logic [IDX_W-1:0]     val_raddr;
  logic [rwa_pkg::VALUE_W-1:0] val_rdata;
  logic [RW-1:0]        rank_rdata;
  logic                 sel_clr;
  rwa_pkg::cmp_t        cmp;
  rwa_pkg::sel_t        sel;
  logic [IDX_W-1:0]     cand;

  assign s_axis_tready_o = (state_q == rwa_pkg::S_LOAD);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign val_we    = s_acc && (count_q < CNT_W'(MAX_ITEMS));
  assign val_re    = (state_q == rwa_pkg::S_SCAN) && (rd_cnt_q < count_q);
  assign val_raddr = rd_cnt_q[IDX_W-1:0];

  assign rank_we = (state_q == rwa_pkg::S_WRITE) && sel.found && !sel.dup;
  assign rank_re = (state_q == rwa_pkg::S_OUT_RD);

  assign sel_clr    = (state_q == rwa_pkg::S_LOAD) || (state_q == rwa_pkg::S_WRITE);
  assign cmp.vld    = cmp_vld_q;
  assign cmp.ranked = ranked_q[cmp_idx_q];

  rwa_ram #(
    .WIDTH (rwa_pkg::VALUE_W),
    .DEPTH (MAX_ITEMS),
    .AW    (IDX_W)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  rwa_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ITEMS),
    .AW    (IDX_W)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (cand),
    .wdata_i (round_q),
    .re_i    (rank_re),
    .raddr_i (out_cnt_q),
    .rdata_o (rank_rdata)
  );

  rwa_select #(
    .IDX_W (IDX_W)
  ) u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (sel_clr),
    .cmp_i  (cmp),
    .idx_i  (cmp_idx_q),
    .data_i (val_rdata),
    .sel_o  (sel),
    .cand_o (cand)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    abort_d    = abort_q;
    round_d    = round_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = val_re;
    cmp_idx_d  = val_raddr;
    ranked_d   = ranked_q;
    out_cnt_d  = out_cnt_q;
    out_vld_d  = out_vld_q;
    out_rank_d = out_rank_q;
    out_last_d = out_last_q;
    rd_cnt_d   = val_re ? rd_cnt_q + CNT_W'(1) : rd_cnt_q;
    case (state_q)
      rwa_pkg::S_LOAD: begin
        if (s_acc) begin
          if (val_we) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            round_d  = RW'(1);
            rd_cnt_d = '0;
            state_d  = rwa_pkg::S_SCAN;
          end
        end
      end
      rwa_pkg::S_SCAN: begin
        if (cmp_vld_q && (CNT_W'(cmp_idx_q) + CNT_W'(1) == count_q)) begin
          state_d = rwa_pkg::S_WRITE;
        end
      end
      rwa_pkg::S_WRITE: begin
        rd_cnt_d = '0;
        if (sel.dup) begin
          abort_d   = 1'b1;
          out_cnt_d = '0;
          state_d   = rwa_pkg::S_OUT_RD;
        end else if (!sel.found) begin
          out_cnt_d = '0;
          state_d   = rwa_pkg::S_OUT_RD;
        end else begin
          ranked_d[cand] = 1'b1;
          round_d        = round_q + RW'(1);
          state_d        = rwa_pkg::S_SCAN;
        end
      end
      rwa_pkg::S_OUT_RD: begin
        state_d = rwa_pkg::S_OUT_CAP;
      end
      rwa_pkg::S_OUT_CAP: begin
        out_rank_d = ranked_q[out_cnt_q] ? rank_rdata : '0;
        out_last_d = (CNT_W'(out_cnt_q) + CNT_W'(1) == count_q);
        out_vld_d  = 1'b1;
        state_d    = rwa_pkg::S_OUT_VLD;
      end
      rwa_pkg::S_OUT_VLD: begin
        if (m_axis_tready_i) begin
          out_vld_d = 1'b0;
          if (out_last_q) begin
            count_d  = '0;
            ovf_d    = 1'b0;
            abort_d  = 1'b0;
            ranked_d = '0;
            state_d  = rwa_pkg::S_LOAD;
          end else begin
            out_cnt_d = out_cnt_q + IDX_W'(1);
            state_d   = rwa_pkg::S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = rwa_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rwa_pkg::S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      abort_q   <= 1'b0;
      round_q   <= '0;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      ranked_q  <= '0;
      out_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      abort_q   <= abort_d;
      round_q   <= round_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      ranked_q  <= ranked_d;
      out_cnt_q <= out_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    out_rank_q <= out_rank_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_rank_q};
  assign m_axis_tuser_o  = {ovf_q, abort_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/core/rwa_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module rwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rwa_select.sv
// Minimum selection and duplicate detection over one scan of the value store.
`default_nettype none
module rwa_select #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire rwa_pkg::cmp_t              cmp_i,
  input  wire logic [IDX_W-1:0]           idx_i,
  input  wire logic [rwa_pkg::VALUE_W-1:0] data_i,
  output rwa_pkg::sel_t                   sel_o,
  output logic      [IDX_W-1:0]           cand_o
);

  rwa_pkg::sel_t                sel_q, sel_d;
  logic [IDX_W-1:0]             cand_q, cand_d;
  logic [rwa_pkg::VALUE_W-1:0]  cv_q, cv_d;

  // ranked entries never tie with unranked ones, so they are skipped
  always_comb begin
    sel_d  = sel_q;
    cand_d = cand_q;
    cv_d   = cv_q;
    if (clr_i) begin
      sel_d = '0;
    end else if (cmp_i.vld && !cmp_i.ranked) begin
      if (!sel_q.found) begin
        sel_d.found = 1'b1;
        cand_d      = idx_i;
        cv_d        = data_i;
      end else if ($signed(data_i) < $signed(cv_q)) begin
        cand_d = idx_i;
        cv_d   = data_i;
      end else if (data_i == cv_q) begin
        sel_d.dup = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else begin
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    cv_q   <= cv_d;
  end

  assign sel_o  = sel_q;
  assign cand_o = cand_q;

endmodule
`default_nettype wire

FILE: rtl/core/rwa_checker.sv
// Port-level checks for the rank assignment core, bound to the top level.
`default_nettype none
module rwa_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("output word changed while stalled");

  a_no_load_in_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a result is pending");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:0] <= 7'(MAX_ITEMS)))
    else $error("rank above capacity");

  a_ranked_without_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[6:0] != 7'd0))
    else $error("zero rank without duplicate abort");

  a_reload_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("input not ready after final result");

endmodule

bind rank_assign_with_duplicate_abort_core rwa_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_rwa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire
